[hdl/tfn_pkg.sv]
// ----------------------------------------------------------------------------
// tfn_pkg: shared types and widths for the triangle face normal block
// Request structs for the vertex and normal channels, datapath widths.
// ----------------------------------------------------------------------------
package tfn_pkg;

  localparam int COORD_BITS  = 16;
  localparam int NORMAL_BITS = 16;
  localparam int FRAC        = NORMAL_BITS - 1;
  localparam int EDGE_W      = COORD_BITS + 1;
  localparam int PROD_W      = 2 * EDGE_W;
  localparam int CROSS_W     = PROD_W + 1;
  localparam int MAG_W       = CROSS_W - 1;
  localparam int SQ_W        = 2 * MAG_W;
  localparam int SUM_W       = SQ_W + 2;
  localparam int TSHIFT      = 2 * FRAC + 2;
  localparam int ACC_W       = SUM_W + TSHIFT + 6;
  localparam int QW          = FRAC + 1;
  localparam int STEPS       = FRAC + 1;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] az;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by_coord;
    logic signed [COORD_BITS-1:0] bz;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic signed [COORD_BITS-1:0] cz;
  } tfn_in_t;

  typedef struct packed {
    logic signed [NORMAL_BITS-1:0] nx;
    logic signed [NORMAL_BITS-1:0] ny;
    logic signed [NORMAL_BITS-1:0] nz;
    logic                          degenerate;
  } tfn_out_t;

endpackage

[hdl/triangle_face_normal.sv]
// ----------------------------------------------------------------------------
// triangle_face_normal: unit face normal of one triangle per request
// Edge vectors, exact cross product, exact rounded division by its length.
// ----------------------------------------------------------------------------
//  channel | ports                          | payload
//  input   | in_valid, in_stall, in_data    | tfn_in_t, three Q8.8 vertices
//  output  | out_valid, out_stall, out_data | tfn_out_t, Q1.15 normal + flag
//
//  One request enters per cycle unless a stalled output freezes the
//  pipeline; each triangle passes through 24 register stages.
//  Seven stages form edges, products, cross product, magnitudes, squares,
//  the squared length and the search start; sixteen stages then settle one
//  quotient bit each, and an output register follows.
//  Reset clears the valid bits only. A stalled output request freezes the
//  whole pipeline and the input.
module triangle_face_normal
  import tfn_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  tfn_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output tfn_out_t out_data
);

  logic adv;
  logic [6:0] v_r;

  logic signed [EDGE_W-1:0]  ux_r, uy_r, uz_r, vx_r, vy_r, vz_r;
  logic signed [PROD_W-1:0]  p_r [6];
  logic signed [CROSS_W-1:0] cr_r [3];
  logic [MAG_W-1:0]          mag_r [3];
  logic [2:0]                neg4_r, neg5_r, neg6_r;
  logic [SQ_W-1:0]           sq_r [3];
  logic [SQ_W-1:0]           sq6_r [3];
  logic [SUM_W-1:0]          sum_r;
  logic                      deg6_r;

  logic [STEPS-1:0]          sv_r;
  logic signed [ACC_W-1:0]   rem_r [STEPS+1][3];
  logic signed [ACC_W-1:0]   bac_r [STEPS+1][3];
  logic [QW-1:0]             q_r   [STEPS+1][3];
  logic signed [ACC_W-1:0]   s_r   [STEPS+1];
  logic [2:0]                neg_r [STEPS+1];
  logic                      deg_r [STEPS+1];

  logic     out_valid_r;
  tfn_out_t out_data_r;

  assign adv       = !(out_valid_r && out_stall);
  assign in_stall  = !adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      sv_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v_r         <= {v_r[5:0], in_valid};
      sv_r        <= {sv_r[STEPS-2:0], v_r[6]};
      out_valid_r <= sv_r[STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // edges
      ux_r <= EDGE_W'(in_data.bx) - EDGE_W'(in_data.ax);
      uy_r <= EDGE_W'(in_data.by_coord) - EDGE_W'(in_data.ay);
      uz_r <= EDGE_W'(in_data.bz) - EDGE_W'(in_data.az);
      vx_r <= EDGE_W'(in_data.cx) - EDGE_W'(in_data.ax);
      vy_r <= EDGE_W'(in_data.cy) - EDGE_W'(in_data.ay);
      vz_r <= EDGE_W'(in_data.cz) - EDGE_W'(in_data.az);
      // products
      p_r[0] <= PROD_W'(uy_r * vz_r);
      p_r[1] <= PROD_W'(uz_r * vy_r);
      p_r[2] <= PROD_W'(uz_r * vx_r);
      p_r[3] <= PROD_W'(ux_r * vz_r);
      p_r[4] <= PROD_W'(ux_r * vy_r);
      p_r[5] <= PROD_W'(uy_r * vx_r);
      // cross product, magnitudes, squares
      for (int i = 0; i < 3; i++) begin
        cr_r[i]  <= CROSS_W'(p_r[2*i]) - CROSS_W'(p_r[2*i+1]);
        mag_r[i] <= cr_r[i][CROSS_W-1] ? MAG_W'(-cr_r[i]) : MAG_W'(cr_r[i]);
        neg4_r[i] <= cr_r[i][CROSS_W-1];
        sq_r[i]  <= mag_r[i] * mag_r[i];
        sq6_r[i] <= sq_r[i];
      end
      neg5_r <= neg4_r;
      neg6_r <= neg5_r;
      sum_r  <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
      deg6_r <= (sq_r[0] == '0) && (sq_r[1] == '0) && (sq_r[2] == '0);
      // search start: q = 0, odd = -1, rem = c^2 * 2^TSHIFT - S
      for (int i = 0; i < 3; i++) begin
        rem_r[0][i] <= (ACC_W'(sq6_r[i]) <<< TSHIFT) - ACC_W'(sum_r);
        bac_r[0][i] <= -ACC_W'(sum_r);
        q_r[0][i]   <= '0;
      end
      s_r[0]   <= ACC_W'(sum_r);
      neg_r[0] <= neg6_r;
      deg_r[0] <= deg6_r;
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar j = 0; j < STEPS; j++) begin : g_step
    localparam int K = FRAC - j;
    logic signed [ACC_W-1:0] trial [3];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        trial[i] = rem_r[j][i] - (bac_r[j][i] <<< (K + 2)) - (s_r[j] <<< (2*K + 2));
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int i = 0; i < 3; i++) begin
          if (!trial[i][ACC_W-1]) begin
            rem_r[j+1][i] <= trial[i];
            bac_r[j+1][i] <= bac_r[j][i] + (s_r[j] <<< (K + 1));
            q_r[j+1][i]   <= q_r[j][i] | (QW'(1) << K);
          end else begin
            rem_r[j+1][i] <= rem_r[j][i];
            bac_r[j+1][i] <= bac_r[j][i];
            q_r[j+1][i]   <= q_r[j][i];
          end
        end
        s_r[j+1]   <= s_r[j];
        neg_r[j+1] <= neg_r[j];
        deg_r[j+1] <= deg_r[j];
      end
    end
  end

  logic [NORMAL_BITS-1:0] comp [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (deg_r[STEPS]) begin
        comp[i] = '0;
      end else if (neg_r[STEPS][i]) begin
        comp[i] = NORMAL_BITS'(~q_r[STEPS][i]) + NORMAL_BITS'(1);
      end else if (q_r[STEPS][i][FRAC]) begin
        comp[i] = {1'b0, {FRAC{1'b1}}};
      end else begin
        comp[i] = NORMAL_BITS'(q_r[STEPS][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.nx         <= comp[0];
      out_data_r.ny         <= comp[1];
      out_data_r.nz         <= comp[2];
      out_data_r.degenerate <= deg_r[STEPS];
    end
  end

  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |->
      out_data.nx == '0 && out_data.ny == '0 && out_data.nz == '0)
    else $error("degenerate normal not zero");

  a_nondeg_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.degenerate |->
      out_data.nx != '0 || out_data.ny != '0 || out_data.nz != '0)
    else $error("normal of a proper triangle is zero");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && sv_r == '0)
    else $error("pipeline not empty after reset");

endmodule

[tb/tfn_normal_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_normal_checker: face normal predictor and scoreboard
// Watches both channels of triangle_face_normal, computes the exact rounded
// unit normal of every accepted triangle and compares it, in order, with
// every accepted normal request.
// ----------------------------------------------------------------------------
module tfn_normal_checker
  import tfn_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  tfn_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  tfn_out_t out_data,
  output int       err_count,
  output int       normals_pending,
  output int       normals_seen,
  output int       flat_seen
);

  tfn_out_t normal_queue[$];

  // Round |c| * 2^FRAC / sqrt(len_sq) to nearest, ties away from zero.
  function automatic logic [NORMAL_BITS-1:0] unit_component(longint c,
                                                            logic [127:0] len_sq);
    logic [127:0] mag, target, odd, lhs;
    longint lo, hi, mid, val;
    mag = (c < 0) ? -c : c;
    target = (mag * mag) << (2 * FRAC + 2);
    lo = 0;
    hi = longint'(1) << FRAC;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      odd = 2 * mid - 1;
      lhs = odd * odd * len_sq;
      if (lhs <= target) lo = mid;
      else hi = mid - 1;
    end
    if (c < 0) begin
      val = -lo;
    end else begin
      val = (lo > (longint'(1) << FRAC) - 1) ? (longint'(1) << FRAC) - 1 : lo;
    end
    return val[NORMAL_BITS-1:0];
  endfunction

  function automatic tfn_out_t face_normal(tfn_in_t t);
    longint ux, uy, uz, vx, vy, vz, cx, cy, cz;
    logic [127:0] len_sq, mx, my, mz;
    tfn_out_t r;
    ux = longint'(t.bx) - longint'(t.ax);
    uy = longint'(t.by_coord) - longint'(t.ay);
    uz = longint'(t.bz) - longint'(t.az);
    vx = longint'(t.cx) - longint'(t.ax);
    vy = longint'(t.cy) - longint'(t.ay);
    vz = longint'(t.cz) - longint'(t.az);
    cx = uy * vz - uz * vy;
    cy = uz * vx - ux * vz;
    cz = ux * vy - uy * vx;
    mx = (cx < 0) ? -cx : cx;
    my = (cy < 0) ? -cy : cy;
    mz = (cz < 0) ? -cz : cz;
    len_sq = mx * mx + my * my + mz * mz;
    r = '0;
    if (len_sq == 0) begin
      r.degenerate = 1'b1;
    end else begin
      r.nx = unit_component(cx, len_sq);
      r.ny = unit_component(cy, len_sq);
      r.nz = unit_component(cz, len_sq);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    tfn_out_t want;
    if (!rst_n) begin
      err_count <= 0;
      normals_seen <= 0;
      flat_seen <= 0;
    end else begin
      if (in_valid && !in_stall) normal_queue.push_back(face_normal(in_data));
      if (out_valid && !out_stall) begin
        normals_seen <= normals_seen + 1;
        if (out_data.degenerate) flat_seen <= flat_seen + 1;
        if (normal_queue.size() == 0) begin
          if (err_count < 10) $display("unexpected normal request: %p", out_data);
          err_count <= err_count + 1;
        end else begin
          want = normal_queue.pop_front();
          if (want !== out_data) begin
            if (err_count < 10)
              $display("normal mismatch: expected nx=%0d ny=%0d nz=%0d deg=%0b, got nx=%0d ny=%0d nz=%0d deg=%0b",
                       want.nx, want.ny, want.nz, want.degenerate,
                       out_data.nx, out_data.ny, out_data.nz, out_data.degenerate);
            err_count <= err_count + 1;
          end
        end
      end
    end
  end

  assign normals_pending = normal_queue.size();

endmodule

[tb/tb_triangle_face_normal.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangle_face_normal: stimulus and verdict for the face normal block
// Sends directed and random triangles with random idle and stall bursts;
// a checker beside the block predicts and compares every normal.
// ----------------------------------------------------------------------------
module tb_triangle_face_normal
  import tfn_pkg::*;
;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  tfn_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  tfn_out_t out_data;
  int       err_count, normals_pending, normals_seen, flat_seen;
  logic     bursts_on;
  int       wait_cycles;

  triangle_face_normal dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  tfn_normal_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .err_count(err_count), .normals_pending(normals_pending),
    .normals_seen(normals_seen), .flat_seen(flat_seen)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  initial begin
    #(20 * 400000);
    $display("timeout");
    $display("TEST FAILED");
    $finish;
  end

  // receiver stall bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (bursts_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(0, 6)) @(posedge clk);
      end
    end
  end

  function automatic tfn_in_t tri_of(int ax, int ay, int az, int bx, int by,
                                     int bz, int cx, int cy, int cz);
    tfn_in_t t;
    t.ax = COORD_BITS'(ax); t.ay = COORD_BITS'(ay); t.az = COORD_BITS'(az);
    t.bx = COORD_BITS'(bx); t.by_coord = COORD_BITS'(by); t.bz = COORD_BITS'(bz);
    t.cx = COORD_BITS'(cx); t.cy = COORD_BITS'(cy); t.cz = COORD_BITS'(cz);
    return t;
  endfunction

  task automatic send_triangle(input tfn_in_t t);
    if (bursts_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic int small_coord();
    return $urandom_range(0, 64) - 32;
  endfunction

  initial begin
    tfn_in_t t;
    logic [159:0] rnd;
    int a0, a1, a2, d0, d1, d2, k;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    bursts_on = 1'b1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // all points equal: zero cross product
    send_triangle(tri_of(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_triangle(tri_of(-32768, 32767, 5, -32768, 32767, 5, -32768, 32767, 5));
    // collinear points
    send_triangle(tri_of(0, 0, 0, 1, 2, 3, 2, 4, 6));
    send_triangle(tri_of(-32768, -32768, -32768, 0, 0, 0, 32767, 32767, 32767));
    // axis aligned: exact +1.0 saturates, -1.0 holds
    send_triangle(tri_of(0, 0, 0, 1, 0, 0, 0, 1, 0));
    send_triangle(tri_of(0, 0, 0, 0, 1, 0, 1, 0, 0));
    send_triangle(tri_of(0, 0, 0, 0, 1, 0, 0, 0, 1));
    send_triangle(tri_of(0, 0, 0, 0, 0, 1, 0, 1, 0));
    send_triangle(tri_of(0, 0, 0, 0, 0, 1, 1, 0, 0));
    send_triangle(tri_of(0, 0, 0, 1, 0, 0, 0, 0, 1));
    // extreme edges
    send_triangle(tri_of(-32768, -32768, -32768, 32767, -32768, -32768,
                         -32768, 32767, -32768));
    send_triangle(tri_of(32767, 32767, 32767, -32768, 32767, -32768,
                         32767, -32768, -32768));
    send_triangle(tri_of(-32768, 32767, -32768, 32767, -32768, 32767,
                         32767, 32767, -32768));
    send_triangle(tri_of(32767, -32768, 0, -32768, 0, 32767, 0, 32767, -32768));
    // diagonal and tiny normals, rounding ties
    send_triangle(tri_of(0, 0, 0, 1, -1, 0, 1, 0, -1));
    send_triangle(tri_of(0, 0, 0, 1, 0, 0, 0, 1, 1));
    send_triangle(tri_of(1, 1, 1, 2, 1, 1, 1, 2, 3));
    send_triangle(tri_of(0, 0, 0, 3, 0, 0, 0, 4, 0));
    send_triangle(tri_of(0, 0, 0, 3, 4, 0, 0, 0, 5));

    for (int i = 0; i < 500; i++) begin
      if (i == 440) bursts_on = 1'b0;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          rnd = {$urandom, $urandom, $urandom, $urandom, $urandom};
          t = rnd[$bits(tfn_in_t)-1:0];
        end
        4, 5: begin
          t = tri_of(small_coord(), small_coord(), small_coord(), small_coord(),
                     small_coord(), small_coord(), small_coord(), small_coord(),
                     small_coord());
        end
        6: begin
          // collinear: c = a + k * (b - a)
          a0 = small_coord(); a1 = small_coord(); a2 = small_coord();
          d0 = small_coord(); d1 = small_coord(); d2 = small_coord();
          k = $urandom_range(0, 6) - 3;
          t = tri_of(a0, a1, a2, a0 + d0, a1 + d1, a2 + d2,
                     a0 + k * d0, a1 + k * d1, a2 + k * d2);
        end
        7: begin
          // axis aligned edges with random lengths and signs
          a0 = $urandom_range(0, 65535) - 32768;
          a1 = $urandom_range(0, 65535) - 32768;
          d0 = $urandom_range(1, 300) * ($urandom_range(0, 1) ? 1 : -1);
          d1 = $urandom_range(1, 300) * ($urandom_range(0, 1) ? 1 : -1);
          t = tri_of(0, a0, a1, d0, a0, a1, 0, a0 + d1, a1);
        end
        default: begin
          t = tri_of($urandom_range(0, 1) ? 32767 : -32768,
                     $urandom_range(0, 1) ? 32767 : -32768,
                     $urandom_range(0, 1) ? 32767 : -32768,
                     $urandom_range(0, 1) ? 32767 : -32768,
                     $urandom_range(0, 1) ? 32767 : -32768,
                     $urandom_range(0, 1) ? 32767 : -32768,
                     $urandom_range(0, 1) ? 32767 : -32768,
                     $urandom_range(0, 1) ? 32767 : -32768,
                     $urandom_range(0, 1) ? 32767 : -32768);
        end
      endcase
      send_triangle(t);
    end
    in_valid <= 1'b0;

    wait_cycles = 0;
    while (normals_pending != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (40) @(posedge clk);

    $display("sent 519 triangles with idle and stall bursts:");
    $display("%0d normals checked, %0d degenerate", normals_seen, flat_seen);
    if (err_count == 0 && normals_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d normals missing", err_count, normals_pending);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/tfn_pkg.sv
hdl/triangle_face_normal.sv
tb/tfn_normal_checker.sv
tb/tb_triangle_face_normal.sv
